>>> rtl/assert_macros.svh
// --------------------------------------------------------------------------
// assertion macros
// shared assertion forms for the timer bank checker
// --------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define STB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stb assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define STB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stb assertion failed");

`endif

>>> rtl/stb_pkg.sv
// --------------------------------------------------------------------------
// stb_pkg
// types and constants of the software timer bank
// --------------------------------------------------------------------------
package stb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_OUT        = 16;
    localparam int POS_W          = 4;
    localparam int CNT_W          = 5;

    typedef enum logic [2:0] {
        ACT_CREATE = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_START  = 3'd2,
        ACT_STOP   = 3'd3,
        ACT_TICK   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        TS_UNUSED    = 2'd0,
        TS_STOPPED   = 2'd1,
        TS_RUNNING   = 2'd2,
        TS_COMPLETED = 2'd3
    } tstate_t;

    typedef enum logic [1:0] {
        RS_OK       = 2'd0,
        RS_INACTIVE = 2'd1,
        RS_STOPPED  = 2'd2
    } rstat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRD,
        S_CEX,
        S_SCAN,
        S_SDRAIN,
        S_FRD,
        S_FEX
    } fsm_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] delay;
        logic [31:0] period;
        logic        repeat_en;
        logic [31:0] match;
        logic [31:0] order;
    } entry_t;

endpackage

>>> rtl/stb_entry_mem.sv
// --------------------------------------------------------------------------
// stb_entry_mem
// timer entry memory, one read and one write port, registered read data;
// per-entry valid bits make never-written entries read as all zero
// --------------------------------------------------------------------------
module stb_entry_mem #(
    parameter int DEPTH = stb_pkg::NUM_TIMERS_DEF,
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output stb_pkg::entry_t      rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  stb_pkg::entry_t      wr_data
);

    stb_pkg::entry_t mem [DEPTH];
    stb_pkg::entry_t mem_q_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? mem_q_reg : '0;

endmodule

>>> rtl/stb_order.sv
// --------------------------------------------------------------------------
// stb_order
// insertion-sorted list of fired timers, smallest age first,
// equal ages keep scan order
// --------------------------------------------------------------------------
module stb_order #(
    parameter int IDX_W = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clr,
    input  logic                        ins,
    input  logic [31:0]                 ins_age,
    input  logic [IDX_W-1:0]            ins_slot,
    input  logic [stb_pkg::POS_W-1:0]   sel,
    output logic [IDX_W-1:0]            sel_slot,
    output logic [stb_pkg::CNT_W-1:0]   cnt
);

    localparam int N = stb_pkg::MAX_OUT;

    logic [31:0]      age_reg  [N];
    logic [IDX_W-1:0] slot_reg [N];
    logic [N-1:0]     vld_reg;
    logic [stb_pkg::CNT_W-1:0] cnt_reg;
    logic [N-1:0]     keep;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            keep[i] = vld_reg[i] && (age_reg[i] <= ins_age);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (!keep[i])
                begin
                    if (i == 0 || keep[(i == 0) ? 0 : i-1])
                    begin
                        age_reg[i]  <= ins_age;
                        slot_reg[i] <= ins_slot;
                    end
                    else
                    begin
                        age_reg[i]  <= age_reg[(i == 0) ? 0 : i-1];
                        slot_reg[i] <= slot_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            cnt_reg <= '0;
        end
        else if (clr)
        begin
            vld_reg <= '0;
            cnt_reg <= '0;
        end
        else if (ins)
        begin
            vld_reg <= {vld_reg[N-2:0], 1'b1};
            if (cnt_reg != stb_pkg::CNT_W'(N))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign sel_slot = slot_reg[sel];
    assign cnt      = cnt_reg;

endmodule

>>> rtl/software_timer_bank_top.sv
// --------------------------------------------------------------------------
// software_timer_bank_top
// bank of software timers: commands on one slot, ticks that scan all
// entries and report expiries, most recently armed first
// --------------------------------------------------------------------------
//  channel  handshake           word
//  input    start / busy        action timer_slot first_delay reload_period
//                               periodic_mode
//  result   done (strobe)       timer_id fired status success tick_now last
//
//  command: read, modify, write back (S_CRD, S_CEX); the result word is
//  registered and the next accept can follow once done has dropped
//  tick: scan of all entries (S_SCAN, S_SDRAIN); the no-expiry word is
//  issued from S_FRD, else the expiries follow in sorted order, one word
//  per S_FRD / S_FEX pair (one entry read each)
//  reset clears the tick counter, arm sequence and all entry valid bits
//  the receiver takes every result; busy stays high until the last one
module software_timer_bank_top #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [3:0]  timer_slot,
    input  logic [31:0] first_delay,
    input  logic [31:0] reload_period,
    input  logic        periodic_mode,
    output logic        done,
    output logic [3:0]  timer_id,
    output logic        fired,
    output logic [1:0]  status,
    output logic        success,
    output logic [31:0] tick_now,
    output logic        last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    stb_pkg::fsm_t state_reg, state_next;

    logic [2:0]  act_reg;
    logic [3:0]  slot_reg;
    logic [31:0] dly_reg;
    logic [31:0] per_reg;
    logic        mode_reg;

    logic [31:0] tick_reg, tick_next;
    logic [31:0] seq_reg, seq_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] scanq_reg, scanq_next;
    logic        pend_reg, pend_next;
    logic [stb_pkg::POS_W-1:0] pos_reg, pos_next;

    logic        done_reg, done_next;
    logic [3:0]  id_reg, id_next;
    logic        fired_reg, fired_next;
    logic [1:0]  stat_reg, stat_next;
    logic        succ_reg, succ_next;
    logic        last_reg, last_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    stb_pkg::entry_t  rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    stb_pkg::entry_t  wr_data;

    logic             ord_clr;
    logic             ord_ins;
    logic [31:0]      ord_age;
    logic [IDX_W-1:0] ord_slot;
    logic [stb_pkg::CNT_W-1:0] ord_cnt;

    logic             accept;
    logic             slot_ok;
    logic [IDX_W-1:0] slot_idx;
    logic [1:0]       cur_st;
    logic             scan_last;
    logic             fire_last;
    logic [31:0]      arm_ticks;

    assign busy      = (state_reg != stb_pkg::S_IDLE) || done_reg;
    assign accept    = start && !busy;
    assign slot_ok   = 32'(slot_reg) < NUM_TIMERS;
    assign slot_idx  = IDX_W'(slot_reg);
    assign cur_st    = slot_ok ? rd_data.status : stb_pkg::TS_UNUSED;
    assign scan_last = scan_reg == IDX_W'(NUM_TIMERS - 1);
    assign fire_last = (stb_pkg::CNT_W'(pos_reg) + 1'b1) == ord_cnt;
    assign arm_ticks = (rd_data.delay != 32'd0) ? rd_data.delay : rd_data.period;
    assign ord_age   = seq_reg - rd_data.order;

    stb_entry_mem #(
        .DEPTH (NUM_TIMERS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    stb_order #(
        .IDX_W (IDX_W)
    ) u_order (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (ord_clr),
        .ins      (ord_ins),
        .ins_age  (ord_age),
        .ins_slot (scanq_reg),
        .sel      (pos_reg),
        .sel_slot (ord_slot),
        .cnt      (ord_cnt)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action == stb_pkg::ACT_TICK) ? stb_pkg::S_SCAN
                                                              : stb_pkg::S_CRD;
                end
            end
            stb_pkg::S_CRD:    state_next = stb_pkg::S_CEX;
            stb_pkg::S_CEX:    state_next = stb_pkg::S_IDLE;
            stb_pkg::S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = stb_pkg::S_SDRAIN;
                end
            end
            stb_pkg::S_SDRAIN: state_next = stb_pkg::S_FRD;
            stb_pkg::S_FRD:
            begin
                state_next = (ord_cnt == '0) ? stb_pkg::S_IDLE : stb_pkg::S_FEX;
            end
            stb_pkg::S_FEX:
            begin
                state_next = fire_last ? stb_pkg::S_IDLE : stb_pkg::S_FRD;
            end
            default:           state_next = stb_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        tick_next  = tick_reg;
        seq_next   = seq_reg;
        scan_next  = scan_reg;
        scanq_next = scan_reg;
        pend_next  = 1'b0;
        pos_next   = pos_reg;
        done_next  = 1'b0;
        id_next    = id_reg;
        fired_next = 1'b0;
        stat_next  = stb_pkg::RS_OK;
        succ_next  = 1'b1;
        last_next  = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = scan_reg;
        wr_en      = 1'b0;
        wr_addr    = slot_idx;
        wr_data    = rd_data;
        ord_clr    = 1'b0;
        ord_ins    = 1'b0;

        case (state_reg)
            stb_pkg::S_IDLE:
            begin
                if (accept && action == stb_pkg::ACT_TICK)
                begin
                    tick_next = tick_reg + 32'd1;
                    scan_next = '0;
                    pos_next  = '0;
                    ord_clr   = 1'b1;
                end
            end
            stb_pkg::S_CRD:
            begin
                rd_en   = slot_ok;
                rd_addr = slot_idx;
            end
            stb_pkg::S_CEX:
            begin
                done_next = 1'b1;
                id_next   = slot_reg;
                case (act_reg)
                    stb_pkg::ACT_CREATE:
                    begin
                        if (!slot_ok)
                        begin
                            stat_next = stb_pkg::RS_INACTIVE;
                            succ_next = 1'b0;
                        end
                        else
                        begin
                            wr_en             = 1'b1;
                            wr_data.status    = stb_pkg::TS_STOPPED;
                            wr_data.delay     = dly_reg;
                            wr_data.period    = per_reg;
                            wr_data.repeat_en = mode_reg;
                            wr_data.match     = 32'd0;
                        end
                    end
                    stb_pkg::ACT_DELETE:
                    begin
                        if (cur_st == stb_pkg::TS_UNUSED)
                        begin
                            stat_next = stb_pkg::RS_INACTIVE;
                            succ_next = 1'b0;
                        end
                        else
                        begin
                            wr_en             = 1'b1;
                            wr_data.status    = stb_pkg::TS_UNUSED;
                            wr_data.delay     = 32'd0;
                            wr_data.period    = 32'd0;
                            wr_data.repeat_en = 1'b0;
                            wr_data.match     = 32'd0;
                        end
                    end
                    stb_pkg::ACT_START:
                    begin
                        if (cur_st == stb_pkg::TS_UNUSED)
                        begin
                            stat_next = stb_pkg::RS_INACTIVE;
                            succ_next = 1'b0;
                        end
                        else
                        begin
                            seq_next       = seq_reg + 32'd1;
                            wr_en          = 1'b1;
                            wr_data.status = stb_pkg::TS_RUNNING;
                            wr_data.match  = tick_reg + arm_ticks;
                            wr_data.order  = seq_reg + 32'd1;
                        end
                    end
                    stb_pkg::ACT_STOP:
                    begin
                        if (cur_st == stb_pkg::TS_UNUSED)
                        begin
                            stat_next = stb_pkg::RS_INACTIVE;
                            succ_next = 1'b0;
                        end
                        else if (cur_st == stb_pkg::TS_RUNNING)
                        begin
                            wr_en          = 1'b1;
                            wr_data.status = stb_pkg::TS_STOPPED;
                        end
                        else
                        begin
                            stat_next = stb_pkg::RS_STOPPED;
                        end
                    end
                    default:
                    begin
                        succ_next = 1'b0;
                    end
                endcase
            end
            stb_pkg::S_SCAN, stb_pkg::S_SDRAIN:
            begin
                // previous read lands now; current read goes out in S_SCAN only
                ord_ins = pend_reg && rd_data.status == stb_pkg::TS_RUNNING
                          && rd_data.match == tick_reg;
                if (state_reg == stb_pkg::S_SCAN)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    if (!scan_last)
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            stb_pkg::S_FRD:
            begin
                if (ord_cnt == '0)
                begin
                    done_next = 1'b1;
                    id_next   = 4'd0;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = ord_slot;
                end
            end
            stb_pkg::S_FEX:
            begin
                wr_en      = 1'b1;
                wr_addr    = ord_slot;
                done_next  = 1'b1;
                id_next    = 4'(ord_slot);
                fired_next = 1'b1;
                last_next  = fire_last;
                pos_next   = pos_reg + 1'b1;
                if (rd_data.repeat_en)
                begin
                    seq_next       = seq_reg + 32'd1;
                    wr_data.status = stb_pkg::TS_RUNNING;
                    wr_data.match  = tick_reg + rd_data.period;
                    wr_data.order  = seq_reg + 32'd1;
                end
                else
                begin
                    wr_data.status = stb_pkg::TS_COMPLETED;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            slot_reg <= timer_slot;
            dly_reg  <= first_delay;
            per_reg  <= reload_period;
            mode_reg <= periodic_mode;
        end
        scanq_reg <= scanq_next;
        id_reg    <= id_next;
        fired_reg <= fired_next;
        stat_reg  <= stat_next;
        succ_reg  <= succ_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stb_pkg::S_IDLE;
            tick_reg  <= '0;
            seq_reg   <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            pos_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            seq_reg   <= seq_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            done_reg  <= done_next;
        end
    end

    assign done     = done_reg;
    assign timer_id = id_reg;
    assign fired    = fired_reg;
    assign status   = stat_reg;
    assign success  = succ_reg;
    assign tick_now = tick_reg;
    assign last     = last_reg;

endmodule

>>> rtl/stb_checker.sv
// --------------------------------------------------------------------------
// stb_checker
// port-level checks of the timer bank handshake and result words
// --------------------------------------------------------------------------
`include "assert_macros.svh"

module stb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       fired,
    input logic [1:0] status,
    input logic       success,
    input logic       last
);

    `STB_ASSERT_NOW(a_done_busy, done, busy)
    `STB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `STB_ASSERT_NOW(a_fired_ok, done && fired, success && status == stb_pkg::RS_OK)
    `STB_ASSERT_NEXT(a_last_gap, done && last, !done)
    `STB_ASSERT_NOW(a_stopped_ok, done && status == stb_pkg::RS_STOPPED, success)

endmodule

bind software_timer_bank_top stb_checker u_stb_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .fired   (fired),
    .status  (status),
    .success (success),
    .last    (last)
);
